@@ sv/vmma_pkg.sv @@
// ---------------------------------------------------------------------------
// vmma_pkg
// Shared widths, constants and codes for the voltmeter min/max/average block.
// ---------------------------------------------------------------------------
package vmma_pkg;

  localparam int ADC_BITS   = 10;
  localparam int COUNT_BITS = 22;
  localparam int SUM_BITS   = COUNT_BITS + ADC_BITS;
  localparam int DSTEP_BITS = $clog2(SUM_BITS);
  localparam int KEY_BITS   = 5;
  localparam int VOLT_BITS  = 4;
  localparam int HUND_BITS  = 7;
  localparam int PROD_BITS  = 2 * ADC_BITS;

  localparam logic [ADC_BITS-1:0]   ADC_MAX       = ADC_BITS'(1023);
  localparam logic [ADC_BITS:0]     ADC_MAX_X2    = (ADC_BITS + 1)'(2046);
  localparam logic [COUNT_BITS-1:0] COUNT_LIMIT   = {COUNT_BITS{1'b1}};
  localparam logic [ADC_BITS-1:0]   FS_RESET      = ADC_BITS'(500);

  // floor(c / 100) = (c * 41) >> 12 for every 10-bit c
  localparam int RECIP_100_MUL   = 41;
  localparam int RECIP_100_SHIFT = 12;
  localparam int CENTI_BITS      = ADC_BITS + 6;
  localparam int CENTI_PER_VOLT  = 100;

  localparam logic [KEY_BITS-1:0] KEY_TRACK = KEY_BITS'(1);
  localparam logic [KEY_BITS-1:0] KEY_HOLD  = KEY_BITS'(2);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_FULL_SCALE = '0;

  // conversion slots
  localparam logic [1:0] CV_NOW = 2'd0;
  localparam logic [1:0] CV_MAX = 2'd1;
  localparam logic [1:0] CV_MIN = 2'd2;
  localparam logic [1:0] CV_AVG = 2'd3;

  // conversion sub-steps
  localparam logic [1:0] PH_MUL   = 2'd0;
  localparam logic [1:0] PH_SCALE = 2'd1;
  localparam logic [1:0] PH_SPLIT = 2'd2;
  localparam logic [1:0] PH_REM   = 2'd3;

endpackage

@@ sv/voltmeter_min_max_average.sv @@
// ---------------------------------------------------------------------------
// voltmeter_min_max_average
// Running min/max/average tracker with centivolt conversion of each value.
// A request runs through the 32-step serial divider for the average, 4 x 4
// steps of the shared multiply/scale unit and the result step, then the block
// returns to idle; it takes no new request before that.
// in_stall is high while a request is in work or its result cannot be parked.
// Synchronous active-low reset: tracking mode, empty statistics, 5.00 V scale.
// ---------------------------------------------------------------------------
module voltmeter_min_max_average import vmma_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ADC_BITS-1:0]   in_sample,
  input  logic [KEY_BITS-1:0]   in_key_code,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_tracking,
  output logic [VOLT_BITS-1:0]  out_now_volts,
  output logic [HUND_BITS-1:0]  out_now_hundredths,
  output logic [VOLT_BITS-1:0]  out_max_volts,
  output logic [HUND_BITS-1:0]  out_max_hundredths,
  output logic [VOLT_BITS-1:0]  out_min_volts,
  output logic [HUND_BITS-1:0]  out_min_hundredths,
  output logic [VOLT_BITS-1:0]  out_avg_volts,
  output logic [HUND_BITS-1:0]  out_avg_hundredths,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_CONV, ST_DONE} state_t;

  state_t                 state_r;
  logic [ADC_BITS-1:0]    fs_r;
  logic                   mode_r;
  logic [ADC_BITS-1:0]    peak_hi_r;
  logic [ADC_BITS-1:0]    peak_lo_r;
  logic [SUM_BITS-1:0]    sum_r;
  logic [COUNT_BITS-1:0]  count_r;
  logic [ADC_BITS-1:0]    sample_r;
  logic [SUM_BITS-1:0]    quo_r;
  logic [COUNT_BITS-1:0]  rem_r;
  logic [DSTEP_BITS-1:0]  dstep_r;
  logic [1:0]             conv_idx_r;
  logic [1:0]             phase_r;
  logic [PROD_BITS-1:0]   prod_r;
  logic [ADC_BITS-1:0]    centi_r;
  logic [VOLT_BITS-1:0]   volts_r;
  logic [VOLT_BITS-1:0]   volts_a [4];
  logic [HUND_BITS-1:0]   hund_a  [4];

  logic                   out_valid_r;
  logic                   out_tracking_r;
  logic [VOLT_BITS-1:0]   out_now_volts_r, out_max_volts_r, out_min_volts_r, out_avg_volts_r;
  logic [HUND_BITS-1:0]   out_now_hund_r, out_max_hund_r, out_min_hund_r, out_avg_hund_r;

  logic                   accept;
  logic                   cfg_wr;
  logic                   mode_nxt;
  logic [ADC_BITS-1:0]    peak_hi_nxt;
  logic [ADC_BITS-1:0]    peak_lo_nxt;
  logic [SUM_BITS-1:0]    sum_nxt;
  logic [COUNT_BITS-1:0]  count_nxt;
  logic [COUNT_BITS:0]    rem_sh;
  logic [COUNT_BITS:0]    rem_diff;
  logic                   rem_ge;
  logic [ADC_BITS-1:0]    avg_val;
  logic [ADC_BITS-1:0]    operand;
  logic [ADC_BITS:0]      scale_rem;
  logic [1:0]             scale_adj;
  logic [ADC_BITS-1:0]    centi_nxt;
  logic [CENTI_BITS-1:0]  centi_x;
  logic [ADC_BITS:0]      hund_w;
  logic                   out_free;

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state_r != ST_IDLE);
  assign out_free   = !out_valid_r || !out_stall;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1:2] == REG_FULL_SCALE) ?
                      CFG_DATA_W'(fs_r) : '0;

  // mode and statistics update for the incoming request
  always_comb begin
    case (in_key_code)
      KEY_TRACK: mode_nxt = 1'b1;
      KEY_HOLD:  mode_nxt = 1'b0;
      default:   mode_nxt = mode_r;
    endcase
    if (mode_nxt) begin
      peak_hi_nxt = (in_sample > peak_hi_r) ? in_sample : peak_hi_r;
      peak_lo_nxt = (in_sample < peak_lo_r) ? in_sample : peak_lo_r;
      if (count_r < COUNT_LIMIT) begin
        sum_nxt   = sum_r + SUM_BITS'(in_sample);
        count_nxt = count_r + COUNT_BITS'(1);
      end else begin
        sum_nxt   = sum_r;
        count_nxt = count_r;
      end
    end else begin
      peak_hi_nxt = in_sample;
      peak_lo_nxt = in_sample;
      sum_nxt     = SUM_BITS'(in_sample);
      count_nxt   = COUNT_BITS'(1);
    end
  end

  // restoring divider step
  assign rem_sh   = {rem_r, quo_r[SUM_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, count_r};
  assign rem_ge   = !rem_diff[COUNT_BITS];

  always_comb begin
    if (count_r == '0) begin
      avg_val = '0;
    end else if (|quo_r[SUM_BITS-1:ADC_BITS]) begin
      avg_val = ADC_MAX;
    end else begin
      avg_val = quo_r[ADC_BITS-1:0];
    end
  end

  always_comb begin
    case (conv_idx_r)
      CV_NOW:  operand = sample_r;
      CV_MAX:  operand = peak_hi_r;
      CV_MIN:  operand = peak_lo_r;
      default: operand = avg_val;
    endcase
  end

  // floor(prod / 1023) from prod >> 10 plus a small correction
  always_comb begin
    scale_rem = {1'b0, prod_r[ADC_BITS-1:0]} + {1'b0, prod_r[PROD_BITS-1:ADC_BITS]};
    if (scale_rem >= ADC_MAX_X2) begin
      scale_adj = 2'd2;
    end else if (scale_rem >= {1'b0, ADC_MAX}) begin
      scale_adj = 2'd1;
    end else begin
      scale_adj = 2'd0;
    end
    centi_nxt = prod_r[PROD_BITS-1:ADC_BITS] + ADC_BITS'(scale_adj);
  end

  assign centi_x = CENTI_BITS'(centi_r) * CENTI_BITS'(RECIP_100_MUL);
  assign hund_w  = {1'b0, centi_r} - (ADC_BITS + 1)'(volts_r) * (ADC_BITS + 1)'(CENTI_PER_VOLT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fs_r        <= FS_RESET;
      mode_r      <= 1'b1;
      peak_hi_r   <= '0;
      peak_lo_r   <= ADC_MAX;
      sum_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      dstep_r     <= '0;
      conv_idx_r  <= CV_NOW;
      phase_r     <= PH_MUL;
    end else begin
      if (cfg_wr && cfg_paddr[CFG_ADDR_W-1:2] == REG_FULL_SCALE) begin
        fs_r <= cfg_pwdata[ADC_BITS-1:0];
      end
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            mode_r    <= mode_nxt;
            peak_hi_r <= peak_hi_nxt;
            peak_lo_r <= peak_lo_nxt;
            sum_r     <= sum_nxt;
            count_r   <= count_nxt;
            sample_r  <= in_sample;
            quo_r     <= sum_nxt;
            rem_r     <= '0;
            dstep_r   <= '0;
            state_r   <= ST_DIV;
          end
        end
        ST_DIV: begin
          quo_r   <= {quo_r[SUM_BITS-2:0], rem_ge};
          rem_r   <= rem_ge ? rem_diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
          dstep_r <= dstep_r + DSTEP_BITS'(1);
          if (dstep_r == DSTEP_BITS'(SUM_BITS - 1)) begin
            conv_idx_r <= CV_NOW;
            phase_r    <= PH_MUL;
            state_r    <= ST_CONV;
          end
        end
        ST_CONV: begin
          case (phase_r)
            PH_MUL:   prod_r  <= PROD_BITS'(operand) * PROD_BITS'(fs_r);
            PH_SCALE: centi_r <= centi_nxt;
            PH_SPLIT: volts_r <= centi_x[CENTI_BITS-1:RECIP_100_SHIFT];
            default: begin
              volts_a[conv_idx_r] <= volts_r;
              hund_a[conv_idx_r]  <= hund_w[HUND_BITS-1:0];
              conv_idx_r          <= conv_idx_r + 2'd1;
              if (conv_idx_r == CV_AVG) begin
                state_r <= ST_DONE;
              end
            end
          endcase
          phase_r <= phase_r + 2'd1;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r     <= 1'b1;
            out_tracking_r  <= mode_r;
            out_now_volts_r <= volts_a[CV_NOW];
            out_now_hund_r  <= hund_a[CV_NOW];
            out_max_volts_r <= mode_r ? volts_a[CV_MAX] : '0;
            out_max_hund_r  <= mode_r ? hund_a[CV_MAX]  : '0;
            out_min_volts_r <= mode_r ? volts_a[CV_MIN] : '0;
            out_min_hund_r  <= mode_r ? hund_a[CV_MIN]  : '0;
            out_avg_volts_r <= mode_r ? volts_a[CV_AVG] : '0;
            out_avg_hund_r  <= mode_r ? hund_a[CV_AVG]  : '0;
            state_r         <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_tracking       = out_tracking_r;
  assign out_now_volts      = out_now_volts_r;
  assign out_now_hundredths = out_now_hund_r;
  assign out_max_volts      = out_max_volts_r;
  assign out_max_hundredths = out_max_hund_r;
  assign out_min_volts      = out_min_volts_r;
  assign out_min_hundredths = out_min_hund_r;
  assign out_avg_volts      = out_avg_volts_r;
  assign out_avg_hundredths = out_avg_hund_r;

endmodule

@@ sv/vmma_checker.sv @@
// ---------------------------------------------------------------------------
// vmma_checker
// Port-level checks on the voltmeter min/max/average block, bound to the top.
// ---------------------------------------------------------------------------
module vmma_checker import vmma_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_tracking,
  input logic [VOLT_BITS-1:0] out_now_volts,
  input logic [HUND_BITS-1:0] out_now_hundredths,
  input logic [VOLT_BITS-1:0] out_max_volts,
  input logic [HUND_BITS-1:0] out_max_hundredths,
  input logic [VOLT_BITS-1:0] out_min_volts,
  input logic [HUND_BITS-1:0] out_min_hundredths,
  input logic [VOLT_BITS-1:0] out_avg_volts,
  input logic [HUND_BITS-1:0] out_avg_hundredths
);

  // a stalled result stays valid and its now fields and average hundredths hold
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_now_volts) &&
    $stable(out_now_hundredths) && $stable(out_avg_hundredths))
    else $error("stalled result changed");

  // a request keeps the block busy on the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted without busy");

  // hold mode blanks the statistics
  a_hold_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tracking |-> out_max_volts == '0 && out_max_hundredths == '0 &&
    out_min_volts == '0 && out_min_hundredths == '0 &&
    out_avg_volts == '0 && out_avg_hundredths == '0)
    else $error("statistics shown in hold mode");

  // hundredths stay below one volt
  a_hund_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_now_hundredths < HUND_BITS'(CENTI_PER_VOLT) &&
    out_max_hundredths < HUND_BITS'(CENTI_PER_VOLT) &&
    out_min_hundredths < HUND_BITS'(CENTI_PER_VOLT) &&
    out_avg_hundredths < HUND_BITS'(CENTI_PER_VOLT))
    else $error("hundredths out of range");

  // tracked minimum never above maximum
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tracking |->
    {out_min_volts, out_min_hundredths} <= {out_max_volts, out_max_hundredths})
    else $error("minimum above maximum");

endmodule

bind voltmeter_min_max_average vmma_checker u_vmma_checker (.*);

@@ dv/voltmeter_min_max_average_test.sv @@
// ---------------------------------------------------------------------------
// voltmeter_min_max_average_test
// Self-checking bench for the voltmeter min/max/average block. A queue of
// requests feeds a clocked driver and a clocked monitor checks every result
// against an in-bench model of the statistics and the centivolt conversion.
// The full-scale register is rewritten between phases, extremes included.
// ---------------------------------------------------------------------------
module voltmeter_min_max_average_test;
  import vmma_pkg::*;

  localparam int CYCLE_LIMIT        = 1500000;
  localparam int SETTLE_CYCLES      = 60;
  localparam int LONG_HOLD_CYCLES   = 700;
  localparam int HOLD_AFTER_RESULTS = 200;
  localparam int QUIET_FIRST        = 1000;
  localparam int QUIET_LAST         = 1300;
  localparam int IDLE_PERCENT       = 13;
  localparam int PHASES             = 6;
  localparam logic [CFG_ADDR_W-1:0] FULL_SCALE_ADDR = {REG_FULL_SCALE, 2'b00};

  typedef struct packed {
    logic [ADC_BITS-1:0] sample;
    logic [KEY_BITS-1:0] key;
  } request_t;

  typedef struct packed {
    logic                 tracking;
    logic [VOLT_BITS-1:0] now_v;
    logic [HUND_BITS-1:0] now_h;
    logic [VOLT_BITS-1:0] max_v;
    logic [HUND_BITS-1:0] max_h;
    logic [VOLT_BITS-1:0] min_v;
    logic [HUND_BITS-1:0] min_h;
    logic [VOLT_BITS-1:0] avg_v;
    logic [HUND_BITS-1:0] avg_h;
  } reading_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ADC_BITS-1:0]   in_sample = '0;
  logic [KEY_BITS-1:0]   in_key_code = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_tracking;
  logic [VOLT_BITS-1:0]  out_now_volts, out_max_volts, out_min_volts, out_avg_volts;
  logic [HUND_BITS-1:0]  out_now_hundredths, out_max_hundredths;
  logic [HUND_BITS-1:0]  out_min_hundredths, out_avg_hundredths;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  voltmeter_min_max_average u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .in_key_code        (in_key_code),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_tracking       (out_tracking),
    .out_now_volts      (out_now_volts),
    .out_now_hundredths (out_now_hundredths),
    .out_max_volts      (out_max_volts),
    .out_max_hundredths (out_max_hundredths),
    .out_min_volts      (out_min_volts),
    .out_min_hundredths (out_min_hundredths),
    .out_avg_volts      (out_avg_volts),
    .out_avg_hundredths (out_avg_hundredths),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // statistics model state
  logic [ADC_BITS-1:0]   scale_setting;
  logic                  mode_tracking;
  logic [ADC_BITS-1:0]   hi_mark;
  logic [ADC_BITS-1:0]   lo_mark;
  logic [SUM_BITS-1:0]   run_sum;
  logic [COUNT_BITS-1:0] run_count;

  request_t pending_requests[$];
  reading_t expected_readings[$];
  int       mismatches = 0;
  int       cycle_count = 0;

  function automatic void split_volts(input logic [ADC_BITS-1:0] value,
                                      output logic [VOLT_BITS-1:0] volts,
                                      output logic [HUND_BITS-1:0] hund);
    int centi;
    centi = int'(value) * int'(scale_setting) / int'(ADC_MAX);
    volts = VOLT_BITS'(centi / CENTI_PER_VOLT);
    hund  = HUND_BITS'(centi % CENTI_PER_VOLT);
  endfunction

  function automatic reading_t predict_reading(input request_t req);
    reading_t            r;
    logic [63:0]         quotient;
    logic [ADC_BITS-1:0] avg;
    if (req.key == KEY_TRACK) mode_tracking = 1'b1;
    else if (req.key == KEY_HOLD) mode_tracking = 1'b0;
    if (mode_tracking) begin
      if (run_count != COUNT_LIMIT) begin
        run_sum   = run_sum + SUM_BITS'(req.sample);
        run_count = run_count + COUNT_BITS'(1);
      end
      if (req.sample > hi_mark) hi_mark = req.sample;
      if (req.sample < lo_mark) lo_mark = req.sample;
    end else begin
      hi_mark   = req.sample;
      lo_mark   = req.sample;
      run_sum   = SUM_BITS'(req.sample);
      run_count = COUNT_BITS'(1);
    end
    r = '0;
    r.tracking = mode_tracking;
    split_volts(req.sample, r.now_v, r.now_h);
    if (mode_tracking) begin
      avg = '0;
      if (run_count != '0) begin
        quotient = 64'(run_sum) / 64'(run_count);
        avg = (quotient > 64'(ADC_MAX)) ? ADC_MAX : ADC_BITS'(quotient);
      end
      split_volts(hi_mark, r.max_v, r.max_h);
      split_volts(lo_mark, r.min_v, r.min_h);
      split_volts(avg, r.avg_v, r.avg_h);
    end
    return r;
  endfunction

  function automatic request_t make_request(input int sample, input int key);
    request_t req;
    req.sample = ADC_BITS'(sample);
    req.key    = KEY_BITS'(key);
    return req;
  endfunction

  function automatic request_t random_request();
    request_t req;
    int       pick;
    case ($urandom_range(9))
      0: req.sample = '0;
      1: req.sample = ADC_MAX;
      2: req.sample = ADC_BITS'($urandom_range(15));
      3: req.sample = ADC_BITS'($urandom_range(1023, 1008));
      default: req.sample = ADC_BITS'($urandom_range(1023));
    endcase
    pick = $urandom_range(99);
    if (pick < 72) req.key = '0;
    else if (pick < 80) req.key = KEY_TRACK;
    else if (pick < 84) req.key = KEY_HOLD;
    else req.key = KEY_BITS'($urandom_range(31, 3));
    return req;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // driver
  always @(posedge clk) begin : driver
    request_t req;
    int       accepted_count;
    int       sender_gap;
    if (!rst_n) begin
      in_valid       <= 1'b0;
      in_sample      <= '0;
      in_key_code    <= '0;
      accepted_count = 0;
      sender_gap     = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_readings.push_back(predict_reading({in_sample, in_key_code}));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (sender_gap > 0) begin
          sender_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!(accepted_count >= QUIET_FIRST && accepted_count < QUIET_LAST) &&
                     $urandom_range(99) < IDLE_PERCENT) begin
          sender_gap = $urandom_range(110, 1) - 1;
          in_valid <= 1'b0;
        end else begin
          req = pending_requests.pop_front();
          in_valid    <= 1'b1;
          in_sample   <= req.sample;
          in_key_code <= req.key;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin : monitor
    reading_t want;
    int       results_seen;
    int       long_hold_left;
    bit       long_hold_done;
    if (!rst_n) begin
      out_stall      <= 1'b0;
      results_seen   = 0;
      long_hold_left = 0;
      long_hold_done = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_readings.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, actual tracking=%0d now=%0d.%02d",
                   $time, out_tracking, out_now_volts, out_now_hundredths);
        end else begin
          want = expected_readings.pop_front();
          check_field("tracking", want.tracking, out_tracking);
          check_field("now_volts", want.now_v, out_now_volts);
          check_field("now_hundredths", want.now_h, out_now_hundredths);
          check_field("max_volts", want.max_v, out_max_volts);
          check_field("max_hundredths", want.max_h, out_max_hundredths);
          check_field("min_volts", want.min_v, out_min_volts);
          check_field("min_hundredths", want.min_h, out_min_hundredths);
          check_field("avg_volts", want.avg_v, out_avg_volts);
          check_field("avg_hundredths", want.avg_h, out_avg_hundredths);
        end
      end
      if (results_seen == HOLD_AFTER_RESULTS && !long_hold_done) begin
        long_hold_left = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (long_hold_left > 0) begin
        long_hold_left--;
        out_stall <= 1'b1;
      end else if (results_seen >= QUIET_FIRST && results_seen < QUIET_LAST) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // sampled mid-cycle so that the edge's queue and valid updates have settled
  task automatic wait_for_drain();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_readings.size() != 0);
  endtask

  task automatic write_full_scale(input logic [ADC_BITS-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= FULL_SCALE_ADDR;
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    scale_setting = value;
  endtask

  initial begin
    int phase_scale[PHASES];
    int phase_items[PHASES];
    scale_setting = FS_RESET;
    mode_tracking = 1'b1;
    hi_mark       = '0;
    lo_mark       = ADC_MAX;
    run_sum       = '0;
    run_count     = '0;
    phase_scale = '{100, 999, $urandom_range(999, 100), 1023, 0, $urandom_range(1023)};
    phase_items = '{300, 350, 350, 350, 100, 350};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset scale: mode keys, unused keys, hold runs, extremes
    pending_requests.push_back(make_request(512, 0));
    pending_requests.push_back(make_request(1023, 0));
    pending_requests.push_back(make_request(0, 0));
    pending_requests.push_back(make_request(300, 3));
    pending_requests.push_back(make_request(700, KEY_HOLD));
    pending_requests.push_back(make_request(100, 0));
    pending_requests.push_back(make_request(1023, 31));
    pending_requests.push_back(make_request(0, 16));
    pending_requests.push_back(make_request(1023, KEY_TRACK));
    pending_requests.push_back(make_request(0, KEY_TRACK));
    pending_requests.push_back(make_request(511, 15));
    pending_requests.push_back(make_request(256, KEY_HOLD));
    pending_requests.push_back(make_request(1, KEY_HOLD));
    pending_requests.push_back(make_request(1022, KEY_TRACK));
    pending_requests.push_back(make_request(341, 8));
    pending_requests.push_back(make_request(682, 4));
    wait_for_drain();

    // full scale beyond 9.99 V: ten whole volts
    write_full_scale(ADC_MAX);
    pending_requests.push_back(make_request(1023, KEY_TRACK));
    pending_requests.push_back(make_request(0, 0));
    pending_requests.push_back(make_request(1023, KEY_HOLD));
    pending_requests.push_back(make_request(512, KEY_TRACK));
    wait_for_drain();

    // zero full scale: everything reads 0.00
    write_full_scale('0);
    pending_requests.push_back(make_request(1023, 0));
    pending_requests.push_back(make_request(0, KEY_HOLD));
    pending_requests.push_back(make_request(777, KEY_TRACK));
    wait_for_drain();

    for (int p = 0; p < PHASES; p++) begin
      write_full_scale(ADC_BITS'(phase_scale[p]));
      for (int i = 0; i < phase_items[p]; i++) pending_requests.push_back(random_request());
      wait_for_drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/vmma_pkg.sv
sv/voltmeter_min_max_average.sv
sv/vmma_checker.sv
dv/voltmeter_min_max_average_test.sv
